@@ rtl/sorted_timer_task_queue_defines.svh @@
// assertion macros for the sorted timer task queue checker
// no dependencies; included by the checker file
`ifndef SORTED_TIMER_TASK_QUEUE_DEFINES_SVH
`define SORTED_TIMER_TASK_QUEUE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define STQ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stq assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define STQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stq assertion failed");

`endif

@@ rtl/stq_pkg.sv @@
// shared types and constants of the sorted timer task queue
// no dependencies; used by controller, datapath and top level
package stq_pkg;

  localparam int RESULTS_CAP = 8;
  localparam logic [15:0] DELAY_CLAMP = 16'hFFFF;
  localparam logic REQ_SCHEDULE = 1'b0;
  localparam logic REQ_CHECK = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_INS,
    ST_WALK,
    ST_CHK,
    ST_FIN
  } stq_state_t;

  typedef struct packed {
    logic ld_req;
    logic ld_m;
    logic rd_cur;
    logic ins_empty;
    logic ins_head;
    logic walk_start;
    logic walk_between;
    logic walk_append;
    logic walk_adv;
    logic pop;
    logic push_pend;
    logic age_now;
    logic push_final;
  } stq_cmd_t;

  typedef struct packed {
    logic is_check;
    logic free_found;
    logic head_valid;
    logic rd_gt_m;
    logic due;
    logic cur_eq_prev;
    logic link_self;
    logic k_full;
    logic k_zero;
    logic out_free;
  } stq_status_t;

endpackage

@@ rtl/stq_ctrl.sv @@
// controller state machine of the sorted timer task queue
// depends on stq_pkg; drives the datapath by commands, reads its status
module stq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  stq_pkg::stq_status_t st,
  output stq_pkg::stq_cmd_t   cmd
);
  import stq_pkg::*;

  stq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_CALC;
      end
      ST_CALC: begin
        state_nxt = st.is_check ? ST_CHK : ST_INS;
      end
      ST_INS: begin
        if (!st.free_found || !st.head_valid || st.rd_gt_m) state_nxt = ST_FIN;
        else state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if ((!st.cur_eq_prev && st.rd_gt_m) || st.link_self) state_nxt = ST_FIN;
      end
      ST_CHK: begin
        if (!st.head_valid || st.k_full || !st.due) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (st.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.ld_req = in_tvalid;
      end
      ST_CALC: begin
        cmd.ld_m = 1'b1;
      end
      ST_INS: begin
        if (st.free_found) begin
          if (!st.head_valid) cmd.ins_empty = 1'b1;
          else if (st.rd_gt_m) cmd.ins_head = 1'b1;
          else cmd.walk_start = 1'b1;
        end
      end
      ST_WALK: begin
        cmd.rd_cur = 1'b1;
        if (!st.cur_eq_prev && st.rd_gt_m) cmd.walk_between = 1'b1;
        else if (st.link_self) cmd.walk_append = 1'b1;
        else cmd.walk_adv = 1'b1;
      end
      ST_CHK: begin
        if (st.head_valid && !st.k_full) begin
          if (st.due) begin
            if (st.k_zero || st.out_free) begin
              cmd.pop = 1'b1;
              cmd.push_pend = !st.k_zero;
            end
          end else begin
            cmd.age_now = 1'b1;
          end
        end
      end
      ST_FIN: begin
        cmd.push_final = st.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

@@ rtl/stq_dpath.sv @@
// datapath of the sorted timer task queue: slot arrays, list walk, aging
// and the output register; depends on stq_pkg, commanded by stq_ctrl
module stq_dpath #(
  parameter int NUM_SLOTS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_req_type,
  input  logic [7:0]           in_task_tag,
  input  logic [31:0]          in_delay_ticks,
  input  logic [31:0]          in_now_tick,
  input  stq_pkg::stq_cmd_t    cmd,
  output stq_pkg::stq_status_t st,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,  // accepted, fired_tag, next_delay, queue_empty
  output logic                 out_tuser,  // fired_valid
  output logic                 out_tlast
);
  import stq_pkg::*;

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int KW = $clog2(RESULTS_CAP + 1);

  logic            valid_r [NUM_SLOTS];
  logic [31:0]     rem_r   [NUM_SLOTS];
  logic [7:0]      tag_r   [NUM_SLOTS];
  logic [IW-1:0]   link_r  [NUM_SLOTS];
  logic [IW-1:0]   head_r;
  logic [31:0]     ref_r;

  logic            req_r;
  logic [7:0]      tagin_r;
  logic [31:0]     delay_r;
  logic [31:0]     now_r;
  logic [31:0]     m_r;
  logic [IW-1:0]   free_r;
  logic [IW-1:0]   prev_r;
  logic [IW-1:0]   cur_r;
  logic [KW-1:0]   k_r;
  logic            res_acc_r;
  logic            res_fv_r;
  logic [7:0]      res_tag_r;
  logic [15:0]     res_nd_r;

  logic            out_valid_r;
  logic            out_acc_r;
  logic            out_fv_r;
  logic [7:0]      out_tag_r;
  logic [15:0]     out_nd_r;
  logic            out_empty_r;
  logic            out_last_r;

  logic [IW-1:0]   rd_idx;
  logic [31:0]     rd_rem;
  logic [7:0]      rd_tag;
  logic [IW-1:0]   rd_link;
  logic [31:0]     elapsed;
  logic [32:0]     sum;
  logic [31:0]     m_calc;
  logic            free_found;
  logic [IW-1:0]   free_idx;
  logic            head_valid;
  logic            out_free;
  logic [15:0]     delay_clamped;
  logic [15:0]     rem_clamped;
  logic [31:0]     age_delta;
  logic            age_en;

  assign rd_idx  = cmd.rd_cur ? cur_r : head_r;
  assign rd_rem  = rem_r[rd_idx];
  assign rd_tag  = tag_r[rd_idx];
  assign rd_link = link_r[rd_idx];
  assign head_valid = valid_r[head_r];

  assign elapsed = now_r - ref_r;
  assign sum     = {1'b0, delay_r} + {1'b0, elapsed};
  assign m_calc  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

  assign delay_clamped = (|delay_r[31:16]) ? DELAY_CLAMP : delay_r[15:0];
  assign rem_clamped   = (|rd_rem[31:16]) ? DELAY_CLAMP : rd_rem[15:0];

  assign out_free  = !out_valid_r || out_tready;
  assign age_en    = cmd.pop || cmd.age_now;
  assign age_delta = cmd.pop ? rd_rem : elapsed;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  always_comb begin
    st.is_check    = (req_r == REQ_CHECK);
    st.free_found  = free_found;
    st.head_valid  = head_valid;
    st.rd_gt_m     = (rd_rem > m_r);
    st.due         = (rd_rem <= elapsed);
    st.cur_eq_prev = (cur_r == prev_r);
    st.link_self   = (rd_link == cur_r);
    st.k_full      = (k_r == KW'(RESULTS_CAP));
    st.k_zero      = (k_r == '0);
    st.out_free    = out_free;
  end

  // slot arrays and list pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NUM_SLOTS; j++) valid_r[j] <= 1'b0;
      head_r <= '0;
      ref_r  <= '0;
    end else begin
      if (cmd.ins_empty) begin
        link_r[free_r] <= free_r;
        head_r <= free_r;
      end
      if (cmd.ins_head) begin
        link_r[free_r] <= head_r;
        head_r <= free_r;
      end
      if (cmd.walk_between) begin
        link_r[free_r] <= cur_r;
        link_r[prev_r] <= free_r;
      end
      if (cmd.walk_append) begin
        link_r[cur_r]  <= free_r;
        link_r[free_r] <= free_r;
      end
      if (cmd.ins_empty || cmd.ins_head || cmd.walk_between || cmd.walk_append) begin
        rem_r[free_r]   <= m_r;
        tag_r[free_r]   <= tagin_r;
        valid_r[free_r] <= 1'b1;
      end
      if (age_en) begin
        for (int j = 0; j < NUM_SLOTS; j++) rem_r[j] <= rem_r[j] - age_delta;
      end
      if (cmd.pop) begin
        valid_r[head_r] <= 1'b0;
        head_r <= rd_link;
        ref_r  <= ref_r + rd_rem;
      end
      if (cmd.age_now) ref_r <= now_r;
    end
  end

  // request registers, walk pointers and staged result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else begin
      if (cmd.ld_req) begin
        req_r     <= in_req_type;
        tagin_r   <= in_task_tag;
        delay_r   <= in_delay_ticks;
        now_r     <= in_now_tick;
        k_r       <= '0;
        res_acc_r <= 1'b0;
        res_fv_r  <= 1'b0;
        res_tag_r <= '0;
        res_nd_r  <= '0;
      end
      if (cmd.ld_m) begin
        m_r    <= m_calc;
        free_r <= free_idx;
      end
      if (cmd.ins_empty || cmd.ins_head) res_nd_r <= delay_clamped;
      if (cmd.ins_empty || cmd.ins_head || cmd.walk_between || cmd.walk_append) begin
        res_acc_r <= 1'b1;
      end
      if (cmd.walk_start) begin
        prev_r <= head_r;
        cur_r  <= rd_link;
      end
      if (cmd.walk_adv) begin
        prev_r <= cur_r;
        cur_r  <= rd_link;
      end
      if (cmd.pop) begin
        k_r       <= k_r + KW'(1);
        res_fv_r  <= 1'b1;
        res_tag_r <= rd_tag;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.push_pend || cmd.push_final) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_pend) begin
      out_acc_r   <= res_acc_r;
      out_fv_r    <= res_fv_r;
      out_tag_r   <= res_tag_r;
      out_nd_r    <= '0;
      out_empty_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else if (cmd.push_final) begin
      out_acc_r   <= res_acc_r;
      out_fv_r    <= res_fv_r;
      out_tag_r   <= res_tag_r;
      out_nd_r    <= (req_r == REQ_CHECK) ? (head_valid ? rem_clamped : 16'd0) : res_nd_r;
      out_empty_r <= !head_valid;
      out_last_r  <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_empty_r, out_nd_r, out_tag_r, out_acc_r};
  assign out_tuser  = out_fv_r;
  assign out_tlast  = out_last_r;

endmodule

@@ rtl/sorted_timer_task_queue.sv @@
// schedule: CALC, INS, then one WALK step per entry examined past the head, then FIN
// check: CALC, CHK pops due tasks (at most 8 fired), FIN; one request in flight
// the schedule length is set by the list walk, one slot read per cycle
// output register lets the next request enter while a result waits
// rst_n synchronous active low: all slots free, head and reference tick zero
module sorted_timer_task_queue #(
  parameter int NUM_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // task_tag, delay_ticks, now_tick
  input  logic        in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // accepted, fired_tag, next_delay, queue_empty
  output logic        out_tuser,  // fired_valid
  output logic        out_tlast
);
  import stq_pkg::*;

  stq_cmd_t    cmd;
  stq_status_t st;

  stq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  stq_dpath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_req_type    (in_tuser),
    .in_task_tag    (in_tdata[7:0]),
    .in_delay_ticks (in_tdata[39:8]),
    .in_now_tick    (in_tdata[71:40]),
    .cmd            (cmd),
    .st             (st),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast)
  );

endmodule

@@ rtl/stq_checker.sv @@
// port-level checker for the sorted timer task queue, bound to the top level
// depends on sorted_timer_task_queue_defines.svh for the assertion macros
`include "sorted_timer_task_queue_defines.svh"

module stq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // one request at a time
  `STQ_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  // stalled result holds
  `STQ_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  // fired task never flagged as queued
  `STQ_ASSERT_SAME(a_fired_not_acc, out_tvalid && out_tuser, !out_tdata[0])
  // only fired tasks precede the final result
  `STQ_ASSERT_SAME(a_nonlast_fired, out_tvalid && !out_tlast, out_tuser)
  // queued task is a single result on a non-empty queue
  `STQ_ASSERT_SAME(a_acc_last, out_tvalid && out_tdata[0], out_tlast && !out_tdata[25])

endmodule

bind sorted_timer_task_queue stq_checker u_stq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
